### design/ppi_pkg.sv
package ppi_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR     = 2'd0,
        CMD_APPEND    = 2'd1,
        CMD_RECOMPUTE = 2'd2,
        CMD_QUERY     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_SINGLE = 3'd2,
        ST_FULL   = 3'd3,
        ST_STALE  = 3'd4,
        ST_ZERO   = 3'd5
    } status_t;

    localparam int ONE_Q16    = 65536;
    localparam int SPAN_MIN   = 655;

endpackage

### design/polyline_progress_interpolator.sv
// Polyline progress interpolator. Commands arrive one transaction at a time on
// the input channel and each produces exactly one result. Clear, append, a
// recompute on fewer than two waypoints and a query on an empty path or on
// stale bounds go straight to the output state after acceptance; a query on a
// single waypoint or a zero-length path first reads and returns the first
// waypoint. A normal query scans the bounds one by one (a read state and a
// compare state each), fetches the lower bound and both waypoints, then per
// axis does a multiply, a 64-step restoring divide and an add, and then
// enters the output state. Recompute, per segment, reads both waypoints,
// squares and sums the three axis differences, runs a 35-step bit-serial
// square root and accumulates the length; then per bound it reads the running
// length, runs a 64-step serial divide and writes the bound, and then enters
// the output state. The next transaction is accepted only once the block is
// idle and the result has been taken. The waypoint and bound
// stores are single-port synchronous memories with registered reads; the
// serial square root and divider set the rate. Only one transaction is
// worked on at a time.
module polyline_progress_interpolator #(
    parameter int MAX_WAYPOINTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [16:0]        progress,
    input  logic signed [31:0] owner_x,
    input  logic signed [31:0] owner_y,
    input  logic signed [31:0] owner_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic [2:0]         status
);

    localparam int AW  = $clog2(MAX_WAYPOINTS);
    localparam int CW  = $clog2(MAX_WAYPOINTS + 1);
    // each segment is below 2^33, so the sum of all of them fits here
    localparam int LW  = 34 + AW;
    localparam int DW  = 64;

    typedef enum logic [4:0] {
        S_IDLE, S_RC_RD0, S_RC_RD1, S_RC_DIFF, S_RC_SQ, S_RC_SQRT,
        S_RC_ACC, S_RC_BRD, S_RC_BDIV, S_RC_BWR,
        S_Q_RD, S_Q_CMP, S_Q_LRD, S_Q_LAT, S_Q_WRD0, S_Q_WRD1, S_Q_WLAT,
        S_Q_MUL, S_Q_DIV, S_Q_ADD, S_OUT
    } state_t;

    // waypoint memory (xyz packed) and per-segment memories
    logic [95:0]   wp_mem [MAX_WAYPOINTS];
    logic [16:0]   bnd_mem [MAX_WAYPOINTS];
    logic [LW-1:0] cum_mem [MAX_WAYPOINTS];

    logic          wp_we;
    logic [AW-1:0] wp_addr;
    logic [95:0]   wp_wdata, wp_rdata;
    logic          bnd_we;
    logic [AW-1:0] bnd_addr;
    logic [16:0]   bnd_wdata, bnd_rdata;
    logic          cum_we;
    logic [AW-1:0] cum_addr;
    logic [LW-1:0] cum_wdata, cum_rdata;

    always_ff @(posedge clk)
    begin
        if (wp_we)
        begin
            wp_mem[wp_addr] <= wp_wdata;
        end
        wp_rdata <= wp_mem[wp_addr];
        if (bnd_we)
        begin
            bnd_mem[bnd_addr] <= bnd_wdata;
        end
        bnd_rdata <= bnd_mem[bnd_addr];
        if (cum_we)
        begin
            cum_mem[cum_addr] <= cum_wdata;
        end
        cum_rdata <= cum_mem[cum_addr];
    end

    state_t        state_reg;
    logic [CW-1:0] count_reg;
    logic          valid_b_reg;
    logic [LW-1:0] total_reg;
    logic [CW-1:0] idx_reg;
    logic [16:0]   prog_reg;
    logic [95:0]   wa_reg, wb_reg;
    logic [95:0]   pos_reg;
    logic [2:0]    status_reg;
    logic          out_valid_reg;
    // arithmetic working registers
    logic [1:0]    ax_reg;
    logic [67:0]   sq_reg;
    logic [34:0]   root_reg;
    logic [5:0]    bit_reg;
    logic [DW-1:0] num_reg, quo_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic          neg_reg;
    logic [16:0]   lower_reg, span_reg;
    logic [16:0]   ival_reg;

    // combinational helpers
    logic [69:0]   cand_sq;
    logic [34:0]   cand;
    logic [DW:0]   rem_sh;
    logic signed [32:0] dsel;
    logic signed [31:0] asel;
    logic [65:0]   dprod;
    logic signed [DW:0] qsigned;
    logic signed [DW:0] sum_s;
    logic [31:0]   sat_v;

    always_comb
    begin
        cand    = root_reg | (35'd1 << bit_reg);
        cand_sq = {35'd0, cand} * {35'd0, cand};
        rem_sh  = {rem_reg[DW-1:0], num_reg[DW-1]};
        case (ax_reg)
            2'd0:    asel = wa_reg[31:0];
            2'd1:    asel = wa_reg[63:32];
            default: asel = wa_reg[95:64];
        endcase
        case (ax_reg)
            2'd0:    dsel = 33'(signed'(wb_reg[31:0]))  - 33'(asel);
            2'd1:    dsel = 33'(signed'(wb_reg[63:32])) - 33'(asel);
            default: dsel = 33'(signed'(wb_reg[95:64])) - 33'(asel);
        endcase
        dprod   = {33'd0, (dsel[32] ? 33'(-dsel) : 33'(dsel))} * {49'd0, 17'(prog_reg - lower_reg)};
        qsigned = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        sum_s   = (DW+1)'(asel) + qsigned;
        if (sum_s > 65'sd2147483647)
            sat_v = 32'h7fffffff;
        else if (sum_s < -65'sd2147483648)
            sat_v = 32'h80000000;
        else
            sat_v = sum_s[31:0];
    end

    // memory port control
    always_comb
    begin
        wp_we     = 1'b0;
        wp_addr   = idx_reg[AW-1:0];
        wp_wdata  = {coord_z, coord_y, coord_x};
        bnd_we    = 1'b0;
        bnd_addr  = idx_reg[AW-1:0];
        bnd_wdata = quo_reg[16:0];
        cum_we    = 1'b0;
        cum_addr  = idx_reg[AW-1:0];
        cum_wdata = total_reg + LW'(root_reg);
        if (state_reg == S_IDLE)
        begin
            wp_addr = count_reg[AW-1:0];
            wp_we   = in_valid && in_ready && cmd == ppi_pkg::CMD_APPEND &&
                      count_reg < CW'(MAX_WAYPOINTS);
        end
        else if (state_reg == S_RC_RD0 || state_reg == S_Q_WRD1)
        begin
            wp_addr = idx_reg[AW-1:0] + AW'(1);
        end
        else if (state_reg == S_RC_ACC)
        begin
            cum_we = 1'b1;
        end
        else if (state_reg == S_RC_BWR)
        begin
            bnd_we = 1'b1;
        end
        else if (state_reg == S_Q_LRD)
        begin
            bnd_addr = idx_reg[AW-1:0] - AW'(1);
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_reg[31:0];
    assign pos_y     = pos_reg[63:32];
    assign pos_z     = pos_reg[95:64];
    assign status    = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            valid_b_reg   <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        prog_reg   <= progress;
                        pos_reg    <= '0;
                        status_reg <= ppi_pkg::ST_OK;
                        idx_reg    <= '0;
                        state_reg  <= S_OUT;
                        case (cmd)
                            ppi_pkg::CMD_CLEAR:
                            begin
                                count_reg   <= '0;
                                valid_b_reg <= 1'b0;
                                total_reg   <= '0;
                            end
                            ppi_pkg::CMD_APPEND:
                            begin
                                if (count_reg >= CW'(MAX_WAYPOINTS))
                                    status_reg <= ppi_pkg::ST_FULL;
                                else
                                begin
                                    count_reg   <= count_reg + CW'(1);
                                    valid_b_reg <= 1'b0;
                                end
                            end
                            ppi_pkg::CMD_RECOMPUTE:
                            begin
                                if (count_reg == '0)
                                    status_reg <= ppi_pkg::ST_EMPTY;
                                else if (count_reg == CW'(1))
                                    status_reg <= ppi_pkg::ST_SINGLE;
                                else
                                begin
                                    total_reg <= '0;
                                    state_reg <= S_RC_RD0;
                                end
                            end
                            default:
                            begin
                                if (count_reg == '0)
                                begin
                                    pos_reg    <= {owner_z, owner_y, owner_x};
                                    status_reg <= ppi_pkg::ST_EMPTY;
                                end
                                else if (!valid_b_reg && count_reg != CW'(1))
                                    status_reg <= ppi_pkg::ST_STALE;
                                else if (count_reg == CW'(1) || total_reg == '0)
                                begin
                                    status_reg <= (count_reg == CW'(1)) ?
                                                  ppi_pkg::ST_SINGLE : ppi_pkg::ST_ZERO;
                                    state_reg  <= S_Q_WRD0;
                                end
                                else
                                    state_reg <= S_Q_RD;
                            end
                        endcase
                    end
                end
                // recompute: read waypoint i+1 then i
                S_RC_RD0:  state_reg <= S_RC_RD1;
                S_RC_RD1:
                begin
                    wa_reg    <= wp_rdata;
                    state_reg <= S_RC_DIFF;
                end
                S_RC_DIFF:
                begin
                    wb_reg    <= wp_rdata;
                    ax_reg    <= 2'd0;
                    sq_reg    <= '0;
                    state_reg <= S_RC_SQ;
                end
                S_RC_SQ:
                begin
                    // accumulate one squared axis difference per cycle
                    sq_reg    <= sq_reg + 68'({34'd0, (dsel[32] ? 33'(-dsel) : 33'(dsel))} *
                                              {34'd0, (dsel[32] ? 33'(-dsel) : 33'(dsel))});
                    if (ax_reg == 2'd2)
                    begin
                        root_reg  <= '0;
                        bit_reg   <= 6'd34;
                        state_reg <= S_RC_SQRT;
                    end
                    ax_reg <= ax_reg + 2'd1;
                end
                S_RC_SQRT:
                begin
                    if (cand_sq <= {2'd0, sq_reg})
                        root_reg <= cand;
                    if (bit_reg == '0)
                        state_reg <= S_RC_ACC;
                    bit_reg <= bit_reg - 6'd1;
                end
                S_RC_ACC:
                begin
                    total_reg <= total_reg + LW'(root_reg);
                    if (idx_reg + CW'(2) >= count_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_RC_BRD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_RC_RD0;
                    end
                end
                S_RC_BRD:
                begin
                    bit_reg   <= 6'd0;
                    ax_reg    <= 2'd3;
                    state_reg <= S_RC_BDIV;
                end
                S_RC_BDIV:
                begin
                    // restoring divide: (cum << 16) / total
                    if (ax_reg == 2'd3)
                    begin
                        if (total_reg == '0)
                        begin
                            quo_reg   <= '0;
                            state_reg <= S_RC_BWR;
                        end
                        else
                        begin
                            num_reg <= DW'({cum_rdata, 16'd0});
                            den_reg <= DW'(total_reg);
                            rem_reg <= '0;
                            quo_reg <= '0;
                            bit_reg <= 6'd63;
                            ax_reg  <= 2'd0;
                        end
                    end
                    else
                    begin
                        num_reg <= num_reg << 1;
                        if (rem_sh >= {1'b0, den_reg})
                        begin
                            rem_reg <= rem_sh - {1'b0, den_reg};
                            quo_reg <= {quo_reg[DW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[DW-2:0], 1'b0};
                        end
                        if (bit_reg == '0)
                            state_reg <= S_RC_BWR;
                        bit_reg <= bit_reg - 6'd1;
                    end
                end
                S_RC_BWR:
                begin
                    if (idx_reg + CW'(2) >= count_reg)
                    begin
                        valid_b_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_RC_BRD;
                    end
                end
                // query: scan bounds in order, reading then comparing each
                S_Q_RD:    state_reg <= S_Q_CMP;
                S_Q_CMP:
                begin
                    if ({15'd0, prog_reg} < {15'd0, bnd_rdata} ||
                        idx_reg + CW'(2) >= count_reg)
                    begin
                        ival_reg  <= bnd_rdata;
                        state_reg <= S_Q_LRD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_Q_RD;
                    end
                end
                S_Q_LRD:   state_reg <= S_Q_LAT;
                S_Q_LAT:
                begin
                    lower_reg <= (idx_reg == '0) ? 17'd0 : bnd_rdata;
                    if (ival_reg - ((idx_reg == '0) ? 17'd0 : bnd_rdata) <= 17'(ppi_pkg::SPAN_MIN))
                        span_reg <= 17'(ppi_pkg::ONE_Q16);
                    else
                        span_reg <= ival_reg - ((idx_reg == '0) ? 17'd0 : bnd_rdata);
                    state_reg <= S_Q_WRD0;
                end
                S_Q_WRD0:  state_reg <= S_Q_WRD1;
                S_Q_WRD1:
                begin
                    wa_reg <= wp_rdata;
                    if (status_reg != ppi_pkg::ST_OK)
                    begin
                        pos_reg   <= wp_rdata;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_Q_WLAT;
                end
                S_Q_WLAT:
                begin
                    wb_reg    <= wp_rdata;
                    ax_reg    <= 2'd0;
                    state_reg <= S_Q_MUL;
                end
                S_Q_MUL:
                begin
                    // |d| * (prog - lower), sign kept aside
                    neg_reg   <= dsel[32];
                    num_reg   <= DW'(dprod);
                    den_reg   <= DW'(span_reg);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    bit_reg   <= 6'd63;
                    state_reg <= S_Q_DIV;
                end
                S_Q_DIV:
                begin
                    num_reg <= num_reg << 1;
                    if (rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        quo_reg <= {quo_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[DW-2:0], 1'b0};
                    end
                    if (bit_reg == '0)
                        state_reg <= S_Q_ADD;
                    bit_reg <= bit_reg - 6'd1;
                end
                S_Q_ADD:
                begin
                    case (ax_reg)
                        2'd0:    pos_reg[31:0]  <= sat_v;
                        2'd1:    pos_reg[63:32] <= sat_v;
                        default: pos_reg[95:64] <= sat_v;
                    endcase
                    if (ax_reg == 2'd2)
                        state_reg <= S_OUT;
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= S_Q_MUL;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
